// ===== rtl/tupe_pkg.sv =====
`default_nettype none

package tupe_pkg;

	// storage sizes
	localparam int IMAGE_BYTES     = 65536;
	localparam int PALETTE_ENTRIES = 256;
	localparam int IMG_AW          = $clog2(IMAGE_BYTES);
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

	// field widths
	localparam int OPCODE_W  = 2;
	localparam int LOAD_AW   = 16;
	localparam int PEN_W     = 8;
	localparam int COLOR_W   = 24;
	localparam int COORD_W   = 8;
	localparam int DIM_W     = 9;
	localparam int CHAN_W    = 8;
	localparam int CFG_IDX_W = 2;

	// slave word layout
	localparam int IN_ADDR_LO  = 0;
	localparam int IN_BYTE_LO  = IN_ADDR_LO + LOAD_AW;
	localparam int IN_COLOR_LO = IN_BYTE_LO + PEN_W;
	localparam int IN_X_LO     = IN_COLOR_LO + COLOR_W;
	localparam int IN_Y_LO     = IN_X_LO + COORD_W;
	localparam int IN_DATA_W   = IN_Y_LO + COORD_W;

	// master word layout
	localparam int OUT_ALPHA_LO = 3 * CHAN_W;
	localparam int OUT_PEN_LO   = OUT_ALPHA_LO + CHAN_W;
	localparam int OUT_DATA_W   = OUT_PEN_LO + PEN_W;

	// sum of block and column terms before wrapping
	localparam int SUM_W = (IMG_AW > 18) ? IMG_AW : 18;

	localparam logic [OPCODE_W-1:0] OP_LOAD_IMAGE   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOAD_PALETTE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FETCH        = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;

	typedef logic [IMG_AW-1:0]  img_addr_t;
	typedef logic [PAL_AW-1:0]  pal_addr_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [PEN_W-1:0]   pen_t;
	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		img_addr_t addr;
		logic      out_of_range;
	} fetch_req_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_IMG  = 4'b0010,
		ST_PAL  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	// exchange pen bits three and four
	function automatic pen_t swap_pen(input pen_t pen);
		swap_pen = {pen[7:5], pen[3], pen[4], pen[2:0]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tupe_addr.sv =====
`default_nettype none

module tupe_addr (
	input  var tupe_pkg::coord_t     x,
	input  var tupe_pkg::coord_t     y,
	input  var tupe_pkg::dim_t       width,
	input  var tupe_pkg::dim_t       height,
	output var tupe_pkg::fetch_req_t req
);
	import tupe_pkg::*;

	logic            swap;
	logic [2:0]      col_x;
	logic [7:0]      row_mult;
	logic [16:0]     prod;
	logic [8:0]      low_bits;
	logic [SUM_W-1:0] sum;

	// block row and row-in-block share one multiply by the width
	assign swap     = y[2] ^ y[1];
	assign col_x    = x[2:0] + {swap, 2'b00};
	assign row_mult = {y[7:4], y[3:2], y[0], 1'b0};
	assign prod     = 17'(row_mult) * 17'(width);
	assign low_bits = {x[7:4], col_x, x[3], y[1]};
	assign sum      = SUM_W'(prod) + SUM_W'(low_bits);

	assign req.addr         = img_addr_t'(sum);
	assign req.out_of_range = ({1'b0, x} >= width) || ({1'b0, y} >= height);

endmodule

`default_nettype wire

// ===== rtl/texture_unswizzle_palette_expand.sv =====
// channel  | direction | handshake         | payload
// s        | in        | s_tvalid/s_tready | s_tdata, s_tuser (opcode)
// m        | out       | m_tvalid/m_tready | m_tdata, m_tuser (out_of_range)
// cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a load word is written into its store as it is taken; a fetch runs through address
// and range check, image read, palette read and output register, with the two memory
// reads in series. a stalled output holds the fetch in ST_OUT.
// reset clears control and sets the size registers to 256; neither store is cleared.
// a new word is taken while a finished result still waits on m.

`default_nettype none

module texture_unswizzle_palette_expand (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// load_address, image_byte, palette_color, pixel_x, pixel_y
	input  wire  [tupe_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode
	input  wire  [tupe_pkg::OPCODE_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// color_first, color_second, color_third, alpha_value, pen_index
	output logic [tupe_pkg::OUT_DATA_W-1:0]    m_tdata,
	// out_of_range
	output logic                               m_tuser,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [tupe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [tupe_pkg::DIM_W-1:0]         cfg_data
);
	import tupe_pkg::*;

	state_t     state_q;
	dim_t       width_q;
	dim_t       height_q;
	fetch_req_t req;
	img_addr_t  addr_q;
	logic       oor_q;
	pen_t       img_rdata_q;
	color_t     pal_rdata_q;
	pen_t       pen_q;
	pen_t       pen_swapped;
	logic       accept;
	logic       out_load;

	logic [LOAD_AW-1:0] load_addr;
	pen_t               load_byte;
	color_t             load_color;
	coord_t             px;
	coord_t             py;

	pen_t   image_mem   [IMAGE_BYTES];
	color_t palette_mem [PALETTE_ENTRIES];

	assign load_addr  = s_tdata[IN_ADDR_LO +: LOAD_AW];
	assign load_byte  = s_tdata[IN_BYTE_LO +: PEN_W];
	assign load_color = s_tdata[IN_COLOR_LO +: COLOR_W];
	assign px         = s_tdata[IN_X_LO +: COORD_W];
	assign py         = s_tdata[IN_Y_LO +: COORD_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid || m_tready);
	assign pen_swapped = swap_pen(img_rdata_q);

	tupe_addr u_addr (
		.x      (px),
		.y      (py),
		.width  (width_q),
		.height (height_q),
		.req    (req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept && s_tuser == OP_FETCH) state_q <= ST_IMG;
				ST_IMG:  state_q <= ST_PAL;
				ST_PAL:  state_q <= ST_OUT;
				ST_OUT:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= req.addr;
			oor_q  <= req.out_of_range;
		end
	end

	// image store
	always_ff @(posedge clk) begin
		if (accept && s_tuser == OP_LOAD_IMAGE) begin
			image_mem[img_addr_t'(load_addr)] <= load_byte;
		end
		if (state_q == ST_IMG) begin
			img_rdata_q <= image_mem[addr_q];
		end
	end

	// palette store
	always_ff @(posedge clk) begin
		if (accept && s_tuser == OP_LOAD_PALETTE) begin
			palette_mem[pal_addr_t'(load_addr[7:0])] <= load_color;
		end
		if (state_q == ST_PAL) begin
			pal_rdata_q <= palette_mem[pal_addr_t'(pen_swapped)];
			pen_q       <= pen_swapped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser <= oor_q;
			m_tdata[OUT_ALPHA_LO +: CHAN_W] <= ALPHA_OPAQUE;
			if (oor_q) begin
				m_tdata[0 +: COLOR_W]        <= '0;
				m_tdata[OUT_PEN_LO +: PEN_W] <= '0;
			end else begin
				m_tdata[0 +: COLOR_W]        <= pal_rdata_q;
				m_tdata[OUT_PEN_LO +: PEN_W] <= pen_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tupe_checker.sv =====
`default_nettype none

module tupe_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                s_tvalid,
	input wire                                s_tready,
	input wire [tupe_pkg::OPCODE_W-1:0]       s_tuser,
	input wire                                m_tvalid,
	input wire                                m_tready,
	input wire [tupe_pkg::OUT_DATA_W-1:0]     m_tdata,
	input wire                                m_tuser
);
	import tupe_pkg::*;

	logic fetch_acc;
	assign fetch_acc = s_tvalid && s_tready && (s_tuser == OP_FETCH);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_ALPHA_LO +: CHAN_W] == ALPHA_OPAQUE)
		else $error("alpha not opaque");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			m_tdata[0 +: COLOR_W] == '0 && m_tdata[OUT_PEN_LO +: PEN_W] == '0)
		else $error("flagged fetch carries colour or pen");

	a_fetch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_acc |=> !s_tready)
		else $error("word taken during fetch");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_acc && !m_tvalid |=> !m_tvalid)
		else $error("result ahead of memory reads");

endmodule

bind texture_unswizzle_palette_expand tupe_checker u_tupe_checker (.*);

`default_nettype wire
